// ----- src/p16atp_pkg.sv -----
// Shared types, constants and helper functions for the posit16 atan(x)/pi unit.
package p16atp_pkg;

  localparam logic [15:0] THR_TINY   = 16'd4925;
  localparam logic [15:0] THR_HUGE   = 16'd27109;
  localparam logic [15:0] ONE_PATT   = 16'h4000;
  localparam logic [31:0] HALF_FX    = 32'h2000_0000;
  localparam logic [31:0] PACK_XOR   = 32'h6000_0000;
  localparam logic [31:0] CORE_DEN   = 32'd843315168;
  localparam logic [31:0] SMALL_DEN  = 32'd843314118;
  localparam logic [6:0]  SMALL_K    = 7'd67;
  localparam logic [63:0] RECIP_NUM  = 64'h0000_0100_0000_0000;
  localparam logic [63:0] ASYM_NUM1  = 64'h0000_0000_0AA5_5000;
  localparam logic [63:0] ASYM_NUM2  = 64'h0002_8BE5_FF80_0000;
  localparam logic [5:0]  PACK_E0    = 6'd34;
  localparam int          POLY_STEPS = 6;
  localparam logic [2:0]  POLY_LAST  = 3'(POLY_STEPS - 1);
  localparam int          DIV_W      = 64;
  localparam int          DIV_CW     = $clog2(DIV_W + 1);

  typedef enum logic [2:0] {CLS_PASS, CLS_TINY, CLS_LOW, CLS_HIGH, CLS_HUGE} cls_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_SQ_WB, OP_POLY, OP_POLY_WB,
    OP_DIV, OP_DIV_WB, OP_NORM, OP_PACK
  } op_t;

  typedef enum logic [2:0] {DS_CORE, DS_SMALL, DS_RECIP, DS_ASYM1, DS_ASYM2} dsel_t;

  typedef enum logic [1:0] {WB_NONE, WB_M, WB_V, WB_HALF} wsel_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
    dsel_t      dsel;
    wsel_t      wsel;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic div_busy;
    logic m_small;
    logic m_norm;
  } sts_t;

  function automatic logic [24:0] poly_k(input logic [2:0] idx);
    logic [24:0] k;
    unique case (idx)
      3'd0:    k = 25'd6969;
      3'd1:    k = 25'd530432;
      3'd2:    k = 25'd1273944;
      3'd3:    k = 25'd2358656;
      3'd4:    k = 25'd9340208;
      3'd5:    k = 25'd17568064;
      default: k = 25'd0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] poly_s(input logic [2:0] idx);
    logic [4:0] s;
    unique case (idx)
      3'd0:    s = 5'd24;
      3'd1:    s = 5'd28;
      3'd2:    s = 5'd28;
      3'd3:    s = 5'd27;
      3'd4:    s = 5'd29;
      3'd5:    s = 5'd24;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // length of the run of bitv starting at bit top and going down
  function automatic logic [3:0] run_len(input logic [15:0] x, input int top, input logic bitv);
    logic [3:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 0; i < 14; i++) begin
      if (i <= top) begin
        if (run && (x[top - i] == bitv)) n = n + 4'd1;
        else run = 1'b0;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // fixed-point operand from magnitude pattern (2^28 = one below one, 2^12 = one for CLS_HIGH, 2^8 = one for CLS_HUGE)
  function automatic logic [39:0] front_v(input logic [15:0] mag, input cls_t cls);
    logic [3:0]  n;
    logic [31:0] ms;
    logic [12:0] mant;
    int          e;
    logic [39:0] v;
    unique case (cls)
      CLS_LOW:  n = run_len(mag, 13, 1'b0);
      CLS_TINY: n = run_len(mag, 12, 1'b0);
      CLS_HIGH: n = run_len(mag, 13, 1'b1);
      default:  n = run_len(mag, 12, 1'b1);
    endcase
    ms = {16'd0, mag} << n;
    unique case (cls)
      CLS_LOW: begin
        e    = 14 - 2 * int'(n) + int'(ms[12]);
        mant = {1'b1, ms[11:0]};
      end
      CLS_TINY: begin
        e    = 13 - 2 * int'(n) + int'(ms[11]);
        mant = {2'b01, ms[10:0]};
      end
      CLS_HIGH: begin
        e    = 2 * int'(n) + int'(ms[12]);
        mant = {1'b1, ms[11:0]};
      end
      default: begin
        e    = -1 + 2 * int'(n) + int'(ms[11]);
        mant = {2'b01, ms[10:0]};
      end
    endcase
    if (e >= 0) v = {27'd0, mant} << e;
    else v = {27'd0, mant} >> (-e);
    return v;
  endfunction

endpackage

// ----- src/p16atp_div.sv -----
// Restoring divider, one quotient bit per cycle.
module p16atp_div import p16atp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]  rem_r, quo_r, dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W+1:0]  diff;

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs_r};
  assign busy     = busy_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CW'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DIV_W+1]) begin
        rem_r <= diff[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/p16atp_dp.sv -----
// Datapath: operand decode, shared multiplier, divider, normalise and posit packing.
module p16atp_dp import p16atp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [15:0] in_operand,
  output sts_t        sts,
  output logic [15:0] out_result
);

  logic [15:0] x_r, res_r;
  logic        neg_r;
  cls_t        cls_r;
  logic [39:0] v_r;
  logic [63:0] p_r;
  logic [28:0] q_r;
  logic [29:0] t_r;
  logic [31:0] m_r;
  logic [5:0]  e_r;

  logic [15:0] mag;
  cls_t        cls_in;
  logic [31:0] mul_a, mul_b;
  logic        div_start, div_busy;
  logic [63:0] div_dd, div_dv, div_quo;
  logic [30:0] mm;
  logic [4:0]  sh;
  logic [31:0] rb, sum, mmx;
  logic        rnd, m_small;
  logic [15:0] mag_res, pack_res;

  always_comb begin
    mag = in_operand[15] ? (~in_operand + 16'd1) : in_operand;
    if (in_operand[14:0] == '0) cls_in = CLS_PASS;
    else if (mag < ONE_PATT) cls_in = (mag > THR_TINY) ? CLS_LOW : CLS_TINY;
    else cls_in = (mag < THR_HUGE) ? CLS_HIGH : CLS_HUGE;
  end

  always_comb begin
    if (cmd.op == OP_POLY) begin
      mul_a = 32'(q_r);
      mul_b = 32'(poly_k(cmd.idx)) - 32'(t_r);
    end else begin
      mul_a = v_r[31:0];
      mul_b = v_r[31:0];
    end
  end

  always_comb begin
    unique case (cmd.dsel)
      DS_CORE: begin
        div_dd = ({24'd0, v_r} + 64'd1) << 30;
        div_dv = 64'(CORE_DEN) + 64'(t_r);
      end
      DS_SMALL: begin
        div_dd = {24'd0, v_r} << 30;
        div_dv = (64'(p_r[63:34]) * 64'(SMALL_K)) + 64'(SMALL_DEN);
      end
      DS_RECIP: begin
        div_dd = RECIP_NUM;
        div_dv = {24'd0, v_r};
      end
      DS_ASYM1: begin
        div_dd = ASYM_NUM1;
        div_dv = {24'd0, v_r};
      end
      default: begin
        div_dd = ASYM_NUM2;
        div_dv = ({24'd0, v_r} << 13) + div_quo;
      end
    endcase
  end

  assign div_start = (cmd.op == OP_DIV);

  p16atp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_dv),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign m_small = (m_r <= 32'd1);

  always_comb begin
    mmx = (32'(m_r[29:0]) ^ PACK_XOR) | (32'(~e_r[0]) << 29);
    mm  = mmx[30:0];
    sh  = e_r[5:1];
    rb  = 32'd1 << (sh - 5'd1);
    rnd = (|(mmx & rb)) && ((|(mmx & (rb - 32'd1))) || (|(mmx & (rb << 1))));
    sum = {1'b0, mm} + (rnd ? rb : 32'd0);
    mag_res = m_small ? m_r[15:0] : 16'(sum >> sh);
    if (cls_r == CLS_PASS) pack_res = x_r;
    else pack_res = neg_r ? (~mag_res + 16'd1) : mag_res;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        x_r   <= in_operand;
        neg_r <= in_operand[15];
        cls_r <= cls_in;
        v_r   <= front_v(mag, cls_in);
      end
      OP_SQ, OP_POLY: p_r <= 64'(mul_a) * 64'(mul_b);
      OP_SQ_WB: begin
        q_r <= p_r[56:28];
        t_r <= '0;
      end
      OP_POLY_WB: t_r <= 30'(p_r >> poly_s(cmd.idx));
      OP_DIV_WB: begin
        e_r <= PACK_E0;
        unique case (cmd.wsel)
          WB_M:    m_r <= div_quo[31:0];
          WB_V:    v_r <= div_quo[39:0];
          WB_HALF: m_r <= HALF_FX - div_quo[31:0];
          default: ;
        endcase
      end
      OP_NORM: begin
        m_r <= {m_r[30:0], 1'b0};
        e_r <= e_r + 6'd1;
      end
      OP_PACK: res_r <= pack_res;
      default: ;
    endcase
  end

  assign sts.cls      = cls_r;
  assign sts.div_busy = div_busy;
  assign sts.m_small  = m_small;
  assign sts.m_norm   = m_r[29];
  assign out_result   = res_r;

endmodule

// ----- src/p16atp_ctrl.sv -----
// Controller: sequences the datapath per request and owns both handshakes.
module p16atp_ctrl import p16atp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_SQ, S_SQ_WB, S_POLY, S_POLY_WB, S_CORE_DIV,
    S_SMALL_DIV, S_ASYM_DIV, S_DIV_WAIT, S_NORM, S_PACK
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  wsel_t      wsel_r, wsel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    wsel_nxt      = wsel_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    cmd.idx       = idx_r;
    cmd.dsel      = DS_CORE;
    cmd.wsel      = wsel_r;
    out_free      = !out_valid_r || !out_stall;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = OP_LOAD;
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        unique case (sts.cls)
          CLS_PASS: state_nxt = S_PACK;
          CLS_LOW: begin
            wsel_nxt  = WB_M;
            state_nxt = S_SQ;
          end
          CLS_TINY: begin
            cmd.op    = OP_SQ;
            state_nxt = S_SMALL_DIV;
          end
          CLS_HIGH: begin
            cmd.op    = OP_DIV;
            cmd.dsel  = DS_RECIP;
            wsel_nxt  = WB_V;
            state_nxt = S_DIV_WAIT;
          end
          default: begin
            cmd.op    = OP_DIV;
            cmd.dsel  = DS_ASYM1;
            wsel_nxt  = WB_NONE;
            state_nxt = S_DIV_WAIT;
          end
        endcase
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SQ_WB;
      end
      S_SQ_WB: begin
        cmd.op    = OP_SQ_WB;
        idx_nxt   = '0;
        state_nxt = S_POLY;
      end
      S_POLY: begin
        cmd.op    = OP_POLY;
        state_nxt = S_POLY_WB;
      end
      S_POLY_WB: begin
        cmd.op = OP_POLY_WB;
        if (idx_r == POLY_LAST) state_nxt = S_CORE_DIV;
        else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_POLY;
        end
      end
      S_CORE_DIV: begin
        cmd.op    = OP_DIV;
        cmd.dsel  = DS_CORE;
        wsel_nxt  = (sts.cls == CLS_HIGH) ? WB_HALF : WB_M;
        state_nxt = S_DIV_WAIT;
      end
      S_SMALL_DIV: begin
        cmd.op    = OP_DIV;
        cmd.dsel  = DS_SMALL;
        wsel_nxt  = WB_M;
        state_nxt = S_DIV_WAIT;
      end
      S_ASYM_DIV: begin
        cmd.op    = OP_DIV;
        cmd.dsel  = DS_ASYM2;
        wsel_nxt  = WB_HALF;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (!sts.div_busy) begin
        cmd.op = OP_DIV_WB;
        unique case (wsel_r)
          WB_V:    state_nxt = S_SQ;
          WB_NONE: state_nxt = S_ASYM_DIV;
          default: state_nxt = S_NORM;
        endcase
      end
      S_NORM: begin
        if (sts.m_small || sts.m_norm) state_nxt = S_PACK;
        else cmd.op = OP_NORM;
      end
      S_PACK: if (out_free) begin
        cmd.op        = OP_PACK;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      wsel_r      <= WB_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      wsel_r      <= wsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/posit16_atan_over_pi_core.sv -----
// Top level of the posit16 (es=1) atan(x)/pi unit.
//
// Input channel: in_valid / in_stall / in_operand, a posit16 pattern.
// Output channel: out_valid / out_stall / out_result, posit16 of atan(x)/pi
// rounded to nearest even. Zero and NaR are returned unchanged.
// A request is taken on a clock edge with valid high and stall low.
// One request is worked on at a time; in_stall is high from acceptance until
// the result is written to the output register.
// A new request can be taken in the cycle after the result is written. The time to
// a result is set by the shared restoring divider (none for zero and NaR, one per
// request below one, two from one up), the shared multiplier (six polynomial
// steps, each a multiply state and a write-back state) and the one-bit-per-cycle
// normalising shift.
// The output register frees the next request: a new operand is accepted while
// a result waits; if out_stall holds, the following result waits to be packed.
// Synchronous active-low reset empties the output and returns to idle.
module posit16_atan_over_pi_core import p16atp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result
);

  cmd_t cmd;
  sts_t sts;

  p16atp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  p16atp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_operand (in_operand),
    .sts        (sts),
    .out_result (out_result)
  );

endmodule
